FILE: src/hardware_stack_with_pop_to_macros.svh
// assertion macros used by the checker
`ifndef HARDWARE_STACK_WITH_POP_TO_MACROS_SVH
`define HARDWARE_STACK_WITH_POP_TO_MACROS_SVH

// same-cycle implication
`define HWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/hws_pkg.sv
package hws_pkg;

  localparam int DATA_W = 64;
  localparam int OCC_W  = 11;

  typedef enum logic [2:0] {
    OP_PUSH         = 3'd0,
    OP_POP          = 3'd1,
    OP_POP_TO       = 3'd2,
    OP_TOP          = 3'd3,
    OP_TOP_THEN_POP = 3'd4,
    OP_NEXT         = 3'd5,
    OP_CLEAR        = 3'd6
  } hws_op_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
  } hws_in_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] data;
    logic [OCC_W-1:0]         occupancy;
    logic [OCC_W-1:0]         free_space;
    logic                     is_empty;
  } hws_out_t;

endpackage

FILE: src/hws_ram.sv
module hws_ram
  import hws_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/hardware_stack_with_pop_to.sv
// LIFO stack of DEPTH signed 64-bit words held in one synchronous RAM.
// Input: an operation (in_item.func, in_item.value) is taken on a rising
// edge with start high and busy low. Output: one result per operation,
// shown on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall it, so it must take every beat.
// push, pop, clear, unused codes and occupancy errors: the result is
// registered straight from the accepting cycle. top, top_then_pop and
// next: one RAM read in state ST_PEEK, then the result. pop_to: state
// ST_SCAN does one RAM read and compare per cycle, from the top down,
// until a match or the bottom; on an empty stack it ends at once.
// busy is low whenever a new operation can be taken, also in the cycle
// the previous result is shown; push/pop/clear run one per cycle while
// no read holds busy high. Rate is set by the single RAM read port.
// Reset (rst_n low, synchronous) empties the stack and drops any
// operation in flight; RAM contents are not cleared and need no pass.
module hardware_stack_with_pop_to
  import hws_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hws_in_t  in_item,
  output logic     out_valid,
  output hws_out_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PEEK,
    ST_SCAN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            cmp_addr_r, cmp_addr_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     out_valid_r, out_valid_nxt;
  hws_out_t                 out_r, out_nxt;

  logic                     we;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;
  logic                     done;
  logic                     res_status;
  logic signed [DATA_W-1:0] res_data;

  hws_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmp_addr_nxt = cmp_addr_r;
    value_nxt    = value_r;
    we           = 1'b0;
    raddr        = cmp_addr_r - AW'(1);
    done         = 1'b0;
    res_status   = STATUS_OK;
    res_data     = '0;

    case (state_r)
      ST_IDLE: begin
        raddr = AW'(cnt_r - CW'(1));
        if (start) begin
          case (in_item.func)
            OP_PUSH: begin
              done = 1'b1;
              if (cnt_r != DEPTH_C) begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            OP_POP: begin
              done = 1'b1;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            OP_POP_TO: begin
              if (cnt_r != '0) begin
                cmp_addr_nxt = AW'(cnt_r - CW'(1));
                value_nxt    = in_item.value;
                state_nxt    = ST_SCAN;
              end else begin
                done = 1'b1;
              end
            end
            OP_TOP: begin
              if (cnt_r != '0) begin
                state_nxt = ST_PEEK;
              end else begin
                done       = 1'b1;
                res_status = STATUS_ERR;
              end
            end
            OP_TOP_THEN_POP: begin
              if (cnt_r != '0) begin
                cnt_nxt   = cnt_r - CW'(1);
                state_nxt = ST_PEEK;
              end else begin
                done       = 1'b1;
                res_status = STATUS_ERR;
              end
            end
            OP_NEXT: begin
              raddr = AW'(cnt_r - CW'(2));
              if (cnt_r >= CW'(2)) begin
                state_nxt = ST_PEEK;
              end else begin
                done       = 1'b1;
                res_status = STATUS_ERR;
              end
            end
            OP_CLEAR: begin
              done    = 1'b1;
              cnt_nxt = '0;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_PEEK: begin
        done      = 1'b1;
        res_data  = $signed(rdata);
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if ($signed(rdata) == value_r) begin
          done      = 1'b1;
          cnt_nxt   = CW'(cmp_addr_r) + CW'(1);
          state_nxt = ST_IDLE;
        end else if (cmp_addr_r == '0) begin
          done      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cmp_addr_nxt = cmp_addr_r - AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = done;
    out_nxt       = out_r;
    if (done) begin
      out_nxt.status     = res_status;
      out_nxt.data       = res_data;
      out_nxt.occupancy  = OCC_W'(cnt_nxt);
      out_nxt.free_space = OCC_W'(DEPTH_C - cnt_nxt);
      out_nxt.is_empty   = (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmp_addr_r <= cmp_addr_nxt;
    value_r    <= value_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

FILE: src/hws_checker.sv
`include "hardware_stack_with_pop_to_macros.svh"

module hws_checker
  import hws_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input hws_in_t  in_item,
  input logic     out_valid,
  input hws_out_t out_item
);

  localparam logic [OCC_W-1:0] DEPTH_O = OCC_W'(DEPTH);

  logic take;
  assign take = start && !busy;

  `HWS_ASSERT_NOW(a_no_beat_while_busy, busy, !out_valid, "result beat while busy")

  `HWS_ASSERT_NOW(a_space_sum, out_valid, OCC_W'(out_item.occupancy + out_item.free_space) == DEPTH_O, "occupancy and free space disagree")

  `HWS_ASSERT_NOW(a_err_zero_data, out_valid && out_item.status == STATUS_ERR, out_item.data == '0, "error beat carries data")

  `HWS_ASSERT_NEXT(a_fast_ops, take && (in_item.func == OP_PUSH || in_item.func == OP_POP || in_item.func == OP_CLEAR), out_valid && out_item.status == STATUS_OK, "push, pop or clear gave no beat")

  `HWS_ASSERT_NEXT(a_clear_empties, take && in_item.func == OP_CLEAR, out_item.is_empty && out_item.occupancy == '0, "clear left entries")

endmodule

bind hardware_stack_with_pop_to hws_checker #(.DEPTH(DEPTH)) u_hws_checker (.*);
